// ===== src/bep_pkg.sv =====
package bep_pkg;

    localparam logic [7:0] ID_SSID      = 8'd0;
    localparam logic [7:0] ID_TPC       = 8'd35;
    localparam logic [7:0] ID_HT        = 8'd45;
    localparam logic [7:0] ID_VHT       = 8'd191;
    localparam logic [7:0] ID_EXT       = 8'd255;
    localparam logic [7:0] EXT_HE_CAP   = 8'd35;
    localparam logic [7:0] EXT_HE_OP    = 8'd36;
    localparam logic [7:0] EXT_EHT_CAP  = 8'd108;
    localparam logic [7:0] TPC_LENGTH   = 8'd2;
    localparam logic [7:0] HE_OP_MIN    = 8'd5;
    localparam logic [7:0] COLOR_OFFSET = 8'd4;

    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] elem_id;
        logic [7:0] elem_len;
        logic [7:0] pay_idx;
        logic [7:0] ext_id;
        logic [7:0] first_byte;
        logic [7:0] color_byte;
        logic       ssid_found;
        logic       ssid_hidden;
        logic       txp_valid;
        logic [3:0] phy_flags;
        logic [7:0] ssid_size;
        logic [7:0] tx_power;
        logic [7:0] color_bits;
    } parse_state_t;

    // Summary as it travels on the result channel, lowest field in bit 0.
    typedef struct packed {
        logic              truncated;
        logic              color_disabled;
        logic              color_partial;
        logic [5:0]        color_code;
        logic [3:0]        phy_flags;
        logic              tx_power_valid;
        logic signed [7:0] tx_power_dbm;
        logic [7:0]        ssid_length;
        logic              ssid_hidden;
        logic              ssid_found;
    } summary_t;

    localparam parse_state_t STATE_RESET = '{
        phase: PH_ID,
        default: '0
    };

endpackage

// ===== src/bep_parse.sv =====
module bep_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              no_data,
    output bep_pkg::summary_t summary
);
    import bep_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t upd;
    logic         commit;

    // One byte advances the element walk; a completed element is folded
    // into the summary fields in the same step.
    always_comb begin
        upd    = state_reg;
        commit = 1'b0;
        if (!no_data) begin
            unique case (state_reg.phase)
                PH_ID: begin
                    upd.elem_id    = data_byte;
                    upd.pay_idx    = '0;
                    upd.ext_id     = '0;
                    upd.first_byte = '0;
                    upd.color_byte = '0;
                    upd.phase      = PH_LEN;
                end
                PH_LEN: begin
                    upd.elem_len = data_byte;
                    if (data_byte == 8'd0) begin
                        commit = 1'b1;
                    end else begin
                        upd.phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (state_reg.pay_idx == 8'd0) begin
                        upd.first_byte = data_byte;
                        if (state_reg.elem_id == ID_EXT) begin
                            upd.ext_id = data_byte;
                        end
                    end
                    if (state_reg.pay_idx == COLOR_OFFSET) begin
                        upd.color_byte = data_byte;
                    end
                    upd.pay_idx = state_reg.pay_idx + 8'd1;
                    if (upd.pay_idx >= state_reg.elem_len) begin
                        commit = 1'b1;
                    end
                end
                default: begin
                    upd.phase = PH_ID;
                end
            endcase
        end

        if (commit) begin
            if (upd.elem_id == ID_SSID) begin
                upd.ssid_found  = 1'b1;
                upd.ssid_hidden = (upd.elem_len == 8'd0);
                upd.ssid_size   = upd.elem_len;
            end
            if (upd.elem_id == ID_TPC && upd.elem_len == TPC_LENGTH) begin
                upd.tx_power  = upd.first_byte;
                upd.txp_valid = 1'b1;
            end
            if (upd.elem_id == ID_HT && upd.elem_len != 8'd0) begin
                upd.phy_flags[0] = 1'b1;
            end
            if (upd.elem_id == ID_VHT && upd.elem_len != 8'd0) begin
                upd.phy_flags[1] = 1'b1;
            end
            if (upd.elem_id == ID_EXT && upd.elem_len != 8'd0) begin
                if (upd.ext_id == EXT_HE_CAP) begin
                    upd.phy_flags[2] = 1'b1;
                end
                if (upd.ext_id == EXT_HE_OP && upd.elem_len >= HE_OP_MIN) begin
                    upd.color_bits = upd.color_byte;
                end
                if (upd.ext_id == EXT_EHT_CAP) begin
                    upd.phy_flags[3] = 1'b1;
                end
            end
            upd.phase = PH_ID;
        end

        summary.ssid_found     = upd.ssid_found;
        summary.ssid_hidden    = upd.ssid_hidden;
        summary.ssid_length    = upd.ssid_size;
        summary.tx_power_dbm   = upd.tx_power;
        summary.tx_power_valid = upd.txp_valid;
        summary.phy_flags      = upd.phy_flags;
        summary.color_code     = upd.color_bits[5:0];
        summary.color_partial  = upd.color_bits[6];
        summary.color_disabled = upd.color_bits[7];
        summary.truncated      = (upd.phase == PH_PAYLOAD);

        // The end of a buffer returns the walk to its starting point.
        state_next = (last_byte || no_data) ? STATE_RESET : upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/beacon_element_parser.sv =====
// Channel  Direction  tdata                      Sideband
// s_       in         data_byte [7:0]            tlast = last_byte, tuser = no_data
// m_       out        summary fields [31:0]      none
//
// Each byte is held in the input register, where the element walk advances
// it, and a byte that ends a buffer then writes the summary to the output
// register, which drives m_tvalid. One transfer can be taken every cycle
// unless a waiting result stalls a closing byte. Reset clears the walk, both
// registers' valid flags and all summary state. A stalled result holds the
// input register only when the byte there closes the next buffer; all other
// bytes keep flowing while a summary waits.
module beacon_element_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // no_data

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] ssid_found, [1] ssid_hidden,
                                   // [9:2] ssid_length, [17:10] tx_power_dbm,
                                   // [18] tx_power_valid, [22:19] phy_flags,
                                   // [28:23] color_code, [29] color_partial,
                                   // [30] color_disabled, [31] truncated
);
    import bep_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_none_reg;

    logic       out_valid_reg;
    summary_t   out_data_reg;

    summary_t   summary;
    logic       ends_buffer;
    logic       out_free;
    logic       advance;

    // The byte in the input register closes a buffer when it is the last
    // byte or a close marker; only then does it need the output slot.
    assign ends_buffer = in_last_reg || in_none_reg;
    assign out_free    = !out_valid_reg || m_tready;
    assign advance     = in_valid_reg && (!ends_buffer || out_free);
    assign s_tready    = !in_valid_reg || advance;

    bep_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .no_data   (in_none_reg),
        .summary   (summary)
    );

    // Input register: loads whenever the slot is empty or its byte moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_none_reg <= s_tuser;
        end
    end

    // Output register: a summary is written as its closing byte advances
    // and is held until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && ends_buffer) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && ends_buffer) begin
            out_data_reg <= summary;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bep_pkg::*;

    // Clock, reset and the two stream channels of the parser.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_tlast  = 1'b0;   // last_byte
    logic        s_tuser  = 1'b0;   // no_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // summary_t, ssid_found in bit 0 up to truncated in bit 31

    always #4 aclk = ~aclk;

    beacon_element_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Summaries that can be read straight off the element rules.
    localparam summary_t SUM_EMPTY  = '0;
    localparam summary_t SUM_TRUNC  = '{truncated: 1'b1, default: '0};
    localparam summary_t SUM_HIDDEN = '{ssid_found: 1'b1, ssid_hidden: 1'b1, default: '0};

    // One row of the directed stimulus. When use_exp is set, exp is the summary
    // the closing transfer must produce; otherwise the element walk below decides.
    typedef struct packed {
        logic [7:0] data;
        logic       lst;
        logic       nd;
        logic       use_exp;
        summary_t   exp;
    } stim_row_t;

    localparam int DIR_ROWS = 32;
    stim_row_t dir_tab [DIR_ROWS] = '{
        // An empty buffer closed with last also set: nothing seen.
        '{8'h00, 1'b1, 1'b1, 1'b1, SUM_EMPTY},
        // SSID declaring five bytes, closed early inside its payload. The byte
        // carried by the close must be ignored.
        '{ID_SSID, 1'b0, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b0, 1'b1, 1'b1, SUM_TRUNC},
        // Hidden SSID, committed at its zero length byte.
        '{ID_SSID, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, 1'b1, SUM_HIDDEN},
        // TPC report with the most negative power, then HT and VHT.
        '{ID_TPC, 1'b0, 1'b0, 1'b0, '0},
        '{TPC_LENGTH, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ID_HT, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{ID_VHT, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, 1'b0, '0},
        // Extension element with no extension id, HE and EHT capabilities, an
        // HE Operation with an all-ones colour byte, and a lone trailing id.
        '{ID_EXT, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{ID_EXT, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{EXT_HE_CAP, 1'b0, 1'b0, 1'b0, '0},
        '{ID_EXT, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{EXT_EHT_CAP, 1'b0, 1'b0, 1'b0, '0},
        '{ID_EXT, 1'b0, 1'b0, 1'b0, '0},
        '{HE_OP_MIN, 1'b0, 1'b0, 1'b0, '0},
        '{EXT_HE_OP, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{ID_SSID, 1'b1, 1'b0, 1'b0, '0}
    };

    summary_t summary_expected_q [$];
    int       fail_count = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    logic     hold_req   = 1'b0;

    // Private copy of the element walk.
    phase_t     w_phase;
    logic [7:0] w_id, w_len, w_idx, w_ext, w_first, w_color;
    logic       w_ssid, w_hidden, w_txp_ok, w_trunc;
    logic [3:0] w_phy;
    logic [7:0] w_ssid_len, w_txp, w_color_bits;

    task automatic clear_walk();
        w_phase      = PH_ID;
        w_id         = '0;
        w_len        = '0;
        w_idx        = '0;
        w_ext        = '0;
        w_first      = '0;
        w_color      = '0;
        w_ssid       = 1'b0;
        w_hidden     = 1'b0;
        w_txp_ok     = 1'b0;
        w_trunc      = 1'b0;
        w_phy        = '0;
        w_ssid_len   = '0;
        w_txp        = '0;
        w_color_bits = '0;
    endtask

    // Effects of an element land only once its final byte is in.
    task automatic commit_element_effects();
        if (w_id == ID_SSID) begin
            w_ssid     = 1'b1;
            w_hidden   = (w_len == 8'd0);
            w_ssid_len = w_len;
        end
        if (w_id == ID_TPC && w_len == TPC_LENGTH) begin
            w_txp    = w_first;
            w_txp_ok = 1'b1;
        end
        if (w_id == ID_HT && w_len != 8'd0)
            w_phy[0] = 1'b1;
        if (w_id == ID_VHT && w_len != 8'd0)
            w_phy[1] = 1'b1;
        if (w_id == ID_EXT && w_len != 8'd0) begin
            if (w_ext == EXT_HE_CAP)
                w_phy[2] = 1'b1;
            if (w_ext == EXT_HE_OP && w_len >= HE_OP_MIN)
                w_color_bits = w_color;
            if (w_ext == EXT_EHT_CAP)
                w_phy[3] = 1'b1;
        end
        w_phase = PH_ID;
    endtask

    // Advances the walk by one accepted transfer and returns the summary it
    // closes, if any.
    task automatic walk_byte(input logic [7:0] b, input logic lst, input logic nd,
                             output logic got, output summary_t res);
        got = 1'b0;
        res = '0;
        if (!nd) begin
            case (w_phase)
                PH_ID: begin
                    w_id    = b;
                    w_idx   = '0;
                    w_ext   = '0;
                    w_first = '0;
                    w_color = '0;
                    w_phase = PH_LEN;
                end
                PH_LEN: begin
                    w_len = b;
                    if (b == 8'd0)
                        commit_element_effects();
                    else
                        w_phase = PH_PAYLOAD;
                end
                default: begin
                    if (w_idx == 8'd0) begin
                        w_first = b;
                        if (w_id == ID_EXT)
                            w_ext = b;
                    end
                    if (w_idx == COLOR_OFFSET)
                        w_color = b;
                    w_idx = w_idx + 8'd1;
                    if (w_idx >= w_len)
                        commit_element_effects();
                end
            endcase
        end
        if (nd || lst) begin
            // Ending inside a payload drops that element and marks the buffer.
            if (w_phase == PH_PAYLOAD)
                w_trunc = 1'b1;
            got                = 1'b1;
            res.ssid_found     = w_ssid;
            res.ssid_hidden    = w_hidden;
            res.ssid_length    = w_ssid_len;
            res.tx_power_dbm   = w_txp;
            res.tx_power_valid = w_txp_ok;
            res.phy_flags      = w_phy;
            res.color_code     = w_color_bits[5:0];
            res.color_partial  = w_color_bits[6];
            res.color_disabled = w_color_bits[7];
            res.truncated      = w_trunc;
            clear_walk();
        end
    endtask

    // Offers one transfer on the input channel. The sender runs in bursts;
    // between bursts tvalid is often dropped. Called and
    // returning just after a falling edge, with tvalid left high.
    task automatic send_item(input logic [7:0] b, input logic lst, input logic nd,
                             input logic use_exp, input summary_t exp);
        logic     got;
        summary_t pred;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        s_tuser  <= nd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        walk_byte(b, lst, nd, got, pred);
        if (got)
            summary_expected_q.push_back(use_exp ? exp : pred);
        items_sent++;
        @(negedge aclk);
    endtask

    // Mostly well-formed buffers with random content, some cut short, some
    // with a lone trailing id, some closed by a no_data transfer.
    task automatic send_random_buffer();
        logic [7:0] bq [$];
        logic [7:0] id;
        int         n_el;
        int         len;
        int         mode;
        logic       close_nd;
        n_el = $urandom_range(0, 6);
        repeat (n_el) begin
            case ($urandom_range(0, 9))
                0:       id = ID_SSID;
                1:       id = ID_TPC;
                2:       id = ID_HT;
                3:       id = ID_VHT;
                4, 5, 6: id = ID_EXT;
                default: id = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 39) == 0)
                len = $urandom_range(0, 255);
            else if (id == ID_TPC && $urandom_range(0, 1) == 1)
                len = int'(TPC_LENGTH);
            else if (id == ID_EXT)
                len = $urandom_range(0, 8);
            else
                len = $urandom_range(0, 7);
            bq.push_back(id);
            bq.push_back(len[7:0]);
            for (int k = 0; k < len; k++) begin
                if (k == 0 && id == ID_EXT) begin
                    case ($urandom_range(0, 3))
                        0:       bq.push_back(EXT_HE_CAP);
                        1:       bq.push_back(EXT_HE_OP);
                        2:       bq.push_back(EXT_EHT_CAP);
                        default: bq.push_back(8'($urandom_range(0, 255)));
                    endcase
                end else begin
                    bq.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        mode = $urandom_range(0, 9);
        if (mode == 0)
            bq.push_back(8'($urandom_range(0, 255)));
        else if ((mode == 1 || mode == 9) && bq.size() > 1)
            bq = bq[0:$urandom_range(0, bq.size() - 2)];
        close_nd = (bq.size() == 0) || (mode >= 8);
        foreach (bq[i])
            send_item(bq[i], !close_nd && (i == bq.size() - 1), 1'b0, 1'b0, '0);
        if (close_nd)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                      1'b0, '0);
    endtask

    // Raw bytes with stray last and no_data marks, closed at the end.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n)
            send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                      $urandom_range(0, 15) == 0, 1'b0, '0);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
    endtask

    // The sender goes quiet until every summary it caused has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (summary_expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic note_field(input string name, input int e, input int a);
        if (e != a) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, e, a);
        end
    endtask

    // Receiver: switches between random stall patterns, and on
    // request holds off for a long stretch so the parser backs up.
    initial begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(10, 80);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    // Each summary transfer is checked field by field against the oldest
    // expectation.
    always @(posedge aclk) begin
        summary_t got_sum;
        summary_t exp_sum;
        if (aresetn && m_tvalid && m_tready) begin
            got_sum = summary_t'(m_tdata);
            if (summary_expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected summary transfer %08h", m_tdata);
            end else begin
                exp_sum = summary_expected_q.pop_front();
                note_field("ssid_found", int'(exp_sum.ssid_found),
                           int'(got_sum.ssid_found));
                note_field("ssid_hidden", int'(exp_sum.ssid_hidden),
                           int'(got_sum.ssid_hidden));
                note_field("ssid_length", int'(exp_sum.ssid_length),
                           int'(got_sum.ssid_length));
                note_field("tx_power_dbm", int'(exp_sum.tx_power_dbm),
                           int'(got_sum.tx_power_dbm));
                note_field("tx_power_valid", int'(exp_sum.tx_power_valid),
                           int'(got_sum.tx_power_valid));
                note_field("phy_flags", int'(exp_sum.phy_flags),
                           int'(got_sum.phy_flags));
                note_field("color_code", int'(exp_sum.color_code),
                           int'(got_sum.color_code));
                note_field("color_partial", int'(exp_sum.color_partial),
                           int'(got_sum.color_partial));
                note_field("color_disabled", int'(exp_sum.color_disabled),
                           int'(got_sum.color_disabled));
                note_field("truncated", int'(exp_sum.truncated),
                           int'(got_sum.truncated));
            end
        end
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int n_buf;
        clear_walk();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].data, dir_tab[i].lst, dir_tab[i].nd,
                      dir_tab[i].use_exp, dir_tab[i].exp);

        n_buf = 0;
        while (items_sent < 1350) begin
            // Long receiver hold-offs while the sender keeps offering bytes.
            if (n_buf == 20 || n_buf == 120)
                hold_req = 1'b1;
            if (n_buf == 70 || n_buf == 170)
                drain_results();
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_random_buffer();
            n_buf++;
        end
        s_tvalid <= 1'b0;

        while (summary_expected_q.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && summary_expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
